FILE: hw/rtl/tlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thresholded line fit package
// Widths, codes, payload word types and the controller/datapath interface
// shared by the thresholded linear regression fit block.
// ----------------------------------------------------------------------------
package tlr_pkg;

    // Field and accumulator widths.
    localparam int PIX_W      = 12;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 44;
    localparam int MAX_PIXELS = 1048576;

    // Multiplier operands are split into two halves; four partial products each.
    localparam int OPD_W     = 44;
    localparam int HALF_W    = OPD_W / 2;
    localparam int PROD_W    = 2 * OPD_W;
    localparam int MUL_STEPS = 4;
    localparam int STEP_W    = 3;

    // Fixed point result and long division sizes.
    localparam int FRAC_W    = 16;
    localparam int RES_W     = 48;
    localparam int NUM_W     = PROD_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Product slots, in the order the controller computes them.
    localparam int NUM_PRODS  = 6;
    localparam int PROD_IDX_W = 3;
    localparam logic [PROD_IDX_W-1:0] PROD_N_SXX   = 3'd0;
    localparam logic [PROD_IDX_W-1:0] PROD_SX_SX   = 3'd1;
    localparam logic [PROD_IDX_W-1:0] PROD_SXX_SY  = 3'd2;
    localparam logic [PROD_IDX_W-1:0] PROD_SX_SXY  = 3'd3;
    localparam logic [PROD_IDX_W-1:0] PROD_N_SXY   = 3'd4;
    localparam logic [PROD_IDX_W-1:0] PROD_SX_SY   = 3'd5;

    // Quotient selects.
    localparam logic DIV_INTERCEPT = 1'b0;
    localparam logic DIV_SLOPE     = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        FIT_OK         = 2'd0,
        FIT_NO_PIXELS  = 2'd1,
        FIT_DEGENERATE = 2'd2
    } fit_status_t;

    // Input word.
    typedef struct packed {
        logic [PIX_W-1:0] ref_pixel;
        logic [PIX_W-1:0] scaled_pixel;
        logic             last_pixel;
    } tlr_in_t;

    // Result word.
    typedef struct packed {
        logic signed [RES_W-1:0] intercept;
        logic signed [RES_W-1:0] slope;
        logic [1:0]              fit_status;
    } tlr_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  acc_en;
        logic                  mul_clear;
        logic                  mul_issue;
        logic [1:0]            chunk;
        logic                  prod_store;
        logic [PROD_IDX_W-1:0] prod_sel;
        logic                  del_load;
        logic                  div_load;
        logic                  div_step;
        logic                  div_store;
        logic                  div_sel;
        logic                  out_load;
        logic [1:0]            fit_status;
    } tlr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_pixel;
        logic count_zero;
        logic del_zero;
        logic out_free;
    } tlr_sts_t;

endpackage

FILE: hw/rtl/thresholded_linear_regression_fit.sv
`timescale 1ns / 1ps
// Timing: a pixel word without the last mark is summed in the cycle it is taken.
// After the last word: a count check, 6 products on one 22x22 multiplier, the
// determinant and its check, 2 divisions (one quotient bit per cycle) and the load,
// during which no word is taken. Throughput: 1 word/cycle while no fit is running.
// Reset (aresetn low, synchronous) clears the sums, the threshold and the result valid.
// ----------------------------------------------------------------------------
// Thresholded linear regression fit
// Streams pixel pairs, sums those at or above a threshold, and on the last
// pair fits intercept and slope in Q31.16 with a status code.
// ----------------------------------------------------------------------------
module thresholded_linear_regression_fit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tlr_pkg::PIX_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tlr_pkg::tlr_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tlr_pkg::tlr_out_t         m_data
);
    import tlr_pkg::*;

    tlr_cmd_t cmd;
    tlr_sts_t sts;

    // The threshold register takes a word in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer.
    tlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Arithmetic and storage.
    tlr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The last word starts the fit, so input stalls in the next cycle.
    a_last_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_pixel) |=> !s_ready)
        else $error("Input still ready after the last word was taken.");

    // Division never overlaps input acceptance.
    a_div_excludes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready)
        else $error("Divider stepping while input is ready.");

    // A result is loaded only into a free result register.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("Result loaded over a word not yet taken.");

    // A failed fit reports zero intercept and slope.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.fit_status != FIT_OK))
        |-> ((m_data.intercept == '0) && (m_data.slope == '0)))
        else $error("Nonzero coefficients on a failed fit.");

endmodule

FILE: hw/rtl/tlr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thresholded line fit controller
// One-hot state machine that takes pixel words, then sequences the products,
// the determinant check, both long divisions and the result load.
// ----------------------------------------------------------------------------
module tlr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tlr_pkg::tlr_sts_t sts,
    output tlr_pkg::tlr_cmd_t cmd
);
    import tlr_pkg::*;

    typedef enum logic [9:0] {
        ST_ACC    = 10'b0000000001,
        ST_CHK    = 10'b0000000010,
        ST_MUL    = 10'b0000000100,
        ST_STORE  = 10'b0000001000,
        ST_DEL    = 10'b0000010000,
        ST_DCHK   = 10'b0000100000,
        ST_DLOAD  = 10'b0001000000,
        ST_DIV    = 10'b0010000000,
        ST_DSTORE = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PROD_IDX_W-1:0]  psel_reg, psel_next;
    logic [DIV_CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                   dsel_reg, dsel_next;
    fit_status_t            status_reg, status_next;

    // Next state and command decode.
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        psel_next   = psel_reg;
        dcnt_next   = dcnt_reg;
        dsel_next   = dsel_reg;
        status_next = status_reg;
        s_ready     = 1'b0;
        cmd            = '0;
        cmd.chunk      = step_reg[1:0];
        cmd.prod_sel   = psel_reg;
        cmd.div_sel    = dsel_reg;
        cmd.fit_status = status_reg;
        case (state_reg)
            ST_ACC: begin
                s_ready       = 1'b1;
                cmd.mul_clear = 1'b1;
                cmd.acc_en    = s_valid;
                if (s_valid && sts.last_pixel) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (sts.count_zero) begin
                    status_next = FIT_NO_PIXELS;
                    state_next  = ST_OUT;
                end else begin
                    psel_next  = PROD_N_SXX;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // Issue four partial products, then wait while the last one is added.
                cmd.mul_issue = (step_reg < STEP_W'(MUL_STEPS));
                if (step_reg == STEP_W'(MUL_STEPS)) begin
                    state_next = ST_STORE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE: begin
                cmd.prod_store = 1'b1;
                cmd.mul_clear  = 1'b1;
                step_next      = '0;
                if (psel_reg == PROD_SX_SY) begin
                    state_next = ST_DEL;
                end else begin
                    psel_next  = psel_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DEL: begin
                cmd.del_load = 1'b1;
                state_next   = ST_DCHK;
            end
            ST_DCHK: begin
                if (sts.del_zero) begin
                    status_next = FIT_DEGENERATE;
                    state_next  = ST_OUT;
                end else begin
                    dsel_next  = DIV_INTERCEPT;
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                    state_next = ST_DSTORE;
                end else begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            ST_DSTORE: begin
                cmd.div_store = 1'b1;
                if (dsel_reg == DIV_SLOPE) begin
                    status_next = FIT_OK;
                    state_next  = ST_OUT;
                end else begin
                    dsel_next  = DIV_SLOPE;
                    state_next = ST_DLOAD;
                end
            end
            ST_OUT: begin
                // Wait for the result register to be free.
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACC;
            step_reg   <= '0;
            psel_reg   <= PROD_N_SXX;
            dcnt_reg   <= '0;
            dsel_reg   <= DIV_INTERCEPT;
            status_reg <= FIT_OK;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            psel_reg   <= psel_next;
            dcnt_reg   <= dcnt_next;
            dsel_reg   <= dsel_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: hw/rtl/tlr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thresholded line fit datapath
// Threshold register, sum accumulators, split multiplier, product slots,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module tlr_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic [tlr_pkg::PIX_W-1:0] cfg_data,
    input  tlr_pkg::tlr_in_t         s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tlr_pkg::tlr_out_t        m_data,
    input  tlr_pkg::tlr_cmd_t        cmd,
    output tlr_pkg::tlr_sts_t        sts
);
    import tlr_pkg::*;

    // Configuration and accumulators.
    logic [PIX_W-1:0]   thr_reg, thr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sx_reg, sx_next;
    logic [SUM_W-1:0]   sy_reg, sy_next;
    logic [SQ_W-1:0]    sxy_reg, sxy_next;
    logic [SQ_W-1:0]    sxx_reg, sxx_next;
    logic [2*PIX_W-1:0] px_xy, px_xx;
    logic               take_pixel;

    // Multiplier.
    logic [OPD_W-1:0]   opa, opb;
    logic [HALF_W-1:0]  half_a, half_b;
    logic [OPD_W-1:0]   pp_reg, pp_next;
    logic [1:0]         pps_reg, pps_next;
    logic               ppv_reg, ppv_next;
    logic [PROD_W-1:0]  pp_aligned;
    logic [PROD_W-1:0]  macc_reg, macc_next;
    logic [PROD_W-1:0]  prod_reg [NUM_PRODS];

    // Divider.
    logic [PROD_W-1:0]  del_reg, del_next;
    logic [PROD_W-1:0]  num_p, num_q, num_mag;
    logic               num_neg;
    logic [NUM_W-1:0]   dividend_reg, dividend_next;
    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [PROD_W:0]    rem_shift, rem_diff;
    logic               rem_take;
    logic [RES_W:0]     quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic [RES_W:0]     quo_limit, quo_sat;
    logic [RES_W-1:0]   quo_signed;
    logic [RES_W-1:0]   icpt_reg, icpt_next;
    logic [RES_W-1:0]   slope_reg, slope_next;

    // Result register.
    logic               mv_reg, mv_next;
    tlr_out_t           md_reg, md_next;

    // Pixel accumulation: pairs at or above threshold, up to the pixel limit.
    assign px_xy      = (2*PIX_W)'(s_data.ref_pixel) * (2*PIX_W)'(s_data.scaled_pixel);
    assign px_xx      = (2*PIX_W)'(s_data.ref_pixel) * (2*PIX_W)'(s_data.ref_pixel);
    assign take_pixel = cmd.acc_en && (s_data.ref_pixel >= thr_reg)
                        && (cnt_reg < CNT_W'(MAX_PIXELS));

    always_comb begin
        thr_next = cfg_valid ? cfg_data : thr_reg;
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxy_next = sxy_reg;
        sxx_next = sxx_reg;
        if (cmd.out_load) begin
            cnt_next = '0;
            sx_next  = '0;
            sy_next  = '0;
            sxy_next = '0;
            sxx_next = '0;
        end else if (take_pixel) begin
            cnt_next = cnt_reg + 1'b1;
            sx_next  = sx_reg + SUM_W'(s_data.ref_pixel);
            sy_next  = sy_reg + SUM_W'(s_data.scaled_pixel);
            sxy_next = sxy_reg + SQ_W'(px_xy);
            sxx_next = sxx_reg + SQ_W'(px_xx);
        end
    end

    // Operand select for the current product slot.
    always_comb begin
        case (cmd.prod_sel)
            PROD_N_SXX: begin
                opa = OPD_W'(cnt_reg);
                opb = sxx_reg;
            end
            PROD_SX_SX: begin
                opa = OPD_W'(sx_reg);
                opb = OPD_W'(sx_reg);
            end
            PROD_SXX_SY: begin
                opa = sxx_reg;
                opb = OPD_W'(sy_reg);
            end
            PROD_SX_SXY: begin
                opa = OPD_W'(sx_reg);
                opb = sxy_reg;
            end
            PROD_N_SXY: begin
                opa = OPD_W'(cnt_reg);
                opb = sxy_reg;
            end
            PROD_SX_SY: begin
                opa = OPD_W'(sx_reg);
                opb = OPD_W'(sy_reg);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // Partial product of one half of each operand, registered.
    assign half_a   = cmd.chunk[1] ? opa[OPD_W-1:HALF_W] : opa[HALF_W-1:0];
    assign half_b   = cmd.chunk[0] ? opb[OPD_W-1:HALF_W] : opb[HALF_W-1:0];
    assign pp_next  = OPD_W'(half_a) * OPD_W'(half_b);
    assign pps_next = {1'b0, cmd.chunk[1]} + {1'b0, cmd.chunk[0]};
    assign ppv_next = cmd.mul_issue;

    // Align the registered partial product and add it into the product.
    always_comb begin
        case (pps_reg)
            2'd0:    pp_aligned = {{OPD_W{1'b0}}, pp_reg};
            2'd1:    pp_aligned = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_aligned = {pp_reg, {OPD_W{1'b0}}};
        endcase
        if (cmd.mul_clear) begin
            macc_next = '0;
        end else if (ppv_reg) begin
            macc_next = macc_reg + pp_aligned;
        end else begin
            macc_next = macc_reg;
        end
    end

    // Determinant, clamped at zero.
    assign del_next = (prod_reg[PROD_N_SXX] >= prod_reg[PROD_SX_SX])
                      ? (prod_reg[PROD_N_SXX] - prod_reg[PROD_SX_SX]) : '0;

    // Numerator magnitude and sign for the selected quotient.
    assign num_p   = (cmd.div_sel == DIV_SLOPE) ? prod_reg[PROD_N_SXY]
                                                 : prod_reg[PROD_SXX_SY];
    assign num_q   = (cmd.div_sel == DIV_SLOPE) ? prod_reg[PROD_SX_SY]
                                                 : prod_reg[PROD_SX_SXY];
    assign num_neg = (num_p < num_q);
    assign num_mag = num_neg ? (num_q - num_p) : (num_p - num_q);

    // One restoring division step.
    assign rem_shift = {rem_reg, dividend_reg[NUM_W-1]};
    assign rem_take  = (rem_shift >= {1'b0, del_reg});
    assign rem_diff  = rem_shift - {1'b0, del_reg};

    // Saturate the quotient and apply the sign.
    assign quo_limit  = neg_reg ? {2'b01, {(RES_W-1){1'b0}}} : {2'b00, {(RES_W-1){1'b1}}};
    assign quo_sat    = (ovf_reg || (quo_reg > quo_limit)) ? quo_limit : quo_reg;
    assign quo_signed = neg_reg ? (RES_W'(0) - quo_sat[RES_W-1:0]) : quo_sat[RES_W-1:0];

    always_comb begin
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        ovf_next      = ovf_reg;
        neg_next      = neg_reg;
        icpt_next     = icpt_reg;
        slope_next    = slope_reg;
        if (cmd.div_load) begin
            dividend_next = {num_mag, {FRAC_W{1'b0}}};
            rem_next      = '0;
            quo_next      = '0;
            ovf_next      = 1'b0;
            neg_next      = num_neg;
        end else if (cmd.div_step) begin
            dividend_next = {dividend_reg[NUM_W-2:0], 1'b0};
            rem_next      = rem_take ? rem_diff[PROD_W-1:0] : rem_shift[PROD_W-1:0];
            quo_next      = {quo_reg[RES_W-1:0], rem_take};
            ovf_next      = ovf_reg | quo_reg[RES_W];
        end
        if (cmd.div_store) begin
            if (cmd.div_sel == DIV_SLOPE) begin
                slope_next = quo_signed;
            end else begin
                icpt_next = quo_signed;
            end
        end
    end

    // Result register: loads when free, clears when the word is taken.
    always_comb begin
        md_next = md_reg;
        mv_next = mv_reg;
        if (cmd.out_load) begin
            md_next.fit_status = cmd.fit_status;
            md_next.intercept  = (cmd.fit_status == FIT_OK) ? icpt_reg : '0;
            md_next.slope      = (cmd.fit_status == FIT_OK) ? slope_reg : '0;
            mv_next            = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    // Control state and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            ppv_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end else begin
            thr_reg <= thr_next;
            cnt_reg <= cnt_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sxy_reg <= sxy_next;
            sxx_reg <= sxx_next;
            ppv_reg <= ppv_next;
            mv_reg  <= mv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pp_reg       <= pp_next;
        pps_reg      <= pps_next;
        macc_reg     <= macc_next;
        del_reg      <= cmd.del_load ? del_next : del_reg;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ovf_reg      <= ovf_next;
        neg_reg      <= neg_next;
        icpt_reg     <= icpt_next;
        slope_reg    <= slope_next;
        md_reg       <= md_next;
        if (cmd.prod_store && (cmd.prod_sel < PROD_IDX_W'(NUM_PRODS))) begin
            prod_reg[cmd.prod_sel] <= macc_reg;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    assign sts.last_pixel = s_data.last_pixel;
    assign sts.count_zero = (cnt_reg == '0);
    assign sts.del_zero   = (del_reg == '0);
    assign sts.out_free   = !mv_reg || m_ready;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fit block testbench
// Drives pixel pair words and threshold writes into the line fit block and
// checks every fit word against a line fit computed here from the accepted
// words. A short directed set of images comes first, then random images
// under three sender/receiver idle patterns and several thresholds.
// ----------------------------------------------------------------------------
module tb_top;
    import tlr_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SEG_WORDS     = 92;

    // Tracks the sums of the image in flight and the fit words still due.
    class fit_scoreboard;
        logic [PIX_W-1:0] threshold;
        logic [CNT_W-1:0] used_count;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]  sum_xy;
        logic [SQ_W-1:0]  sum_xx;
        tlr_out_t         fits_due[$];
        int               errors;

        function void clear_sums();
            used_count = '0;
            sum_x      = '0;
            sum_y      = '0;
            sum_xy     = '0;
            sum_xx     = '0;
        endfunction

        function void reset_state();
            threshold = '0;
            errors    = 0;
            clear_sums();
        endfunction

        function int pending();
            return fits_due.size();
        endfunction

        // (p - q) / del in Q.16, truncated toward zero and saturated to 48 bits.
        function logic [RES_W-1:0] q16_quotient(input logic [127:0] p,
                                                 input logic [127:0] q,
                                                 input logic [127:0] del);
            logic             neg;
            logic [127:0]     mag;
            logic [127:0]     quo;
            logic [RES_W-1:0] limit;
            logic [RES_W-1:0] v;
            neg   = (p < q);
            mag   = neg ? (q - p) : (p - q);
            quo   = (mag << FRAC_W) / del;
            limit = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            v     = (quo > {80'd0, limit}) ? limit : quo[RES_W-1:0];
            if (neg) begin
                v = -v;
            end
            return v;
        endfunction

        // Adds an accepted pixel word; the last word of an image yields a fit.
        function void note_pixel(input tlr_in_t w);
            logic [127:0] n_w;
            logic [127:0] sx_w;
            logic [127:0] sy_w;
            logic [127:0] sxy_w;
            logic [127:0] sxx_w;
            logic [127:0] del;
            tlr_out_t     fit;
            if (w.ref_pixel >= threshold && used_count < CNT_W'(MAX_PIXELS)) begin
                used_count = used_count + 1'b1;
                sum_x      = sum_x + SUM_W'(w.ref_pixel);
                sum_y      = sum_y + SUM_W'(w.scaled_pixel);
                sum_xy     = sum_xy + SQ_W'(w.ref_pixel) * SQ_W'(w.scaled_pixel);
                sum_xx     = sum_xx + SQ_W'(w.ref_pixel) * SQ_W'(w.ref_pixel);
            end
            if (!w.last_pixel) begin
                return;
            end
            fit.intercept = '0;
            fit.slope     = '0;
            n_w   = 128'(used_count);
            sx_w  = 128'(sum_x);
            sy_w  = 128'(sum_y);
            sxy_w = 128'(sum_xy);
            sxx_w = 128'(sum_xx);
            if (used_count == '0) begin
                fit.fit_status = FIT_NO_PIXELS;
            end else begin
                del = (n_w * sxx_w >= sx_w * sx_w) ? (n_w * sxx_w - sx_w * sx_w) : '0;
                if (del == '0) begin
                    fit.fit_status = FIT_DEGENERATE;
                end else begin
                    fit.intercept  = q16_quotient(sxx_w * sy_w, sx_w * sxy_w, del);
                    fit.slope      = q16_quotient(n_w * sxy_w, sx_w * sy_w, del);
                    fit.fit_status = FIT_OK;
                end
            end
            fits_due.push_back(fit);
            clear_sums();
        endfunction

        // Compares a fit word from the block with the oldest one due.
        function void check_fit(input tlr_out_t got);
            tlr_out_t want;
            if (fits_due.size() == 0) begin
                $display("%0t: unexpected fit word, expected none, got a=%0d b=%0d status=%0d",
                         $time, $signed(got.intercept), $signed(got.slope), got.fit_status);
                errors++;
                return;
            end
            want = fits_due.pop_front();
            if (got.intercept !== want.intercept) begin
                $display("%0t: intercept expected %0d, got %0d",
                         $time, $signed(want.intercept), $signed(got.intercept));
                errors++;
            end
            if (got.slope !== want.slope) begin
                $display("%0t: slope expected %0d, got %0d",
                         $time, $signed(want.slope), $signed(got.slope));
                errors++;
            end
            if (got.fit_status !== want.fit_status) begin
                $display("%0t: fit_status expected %0d, got %0d",
                         $time, want.fit_status, got.fit_status);
                errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [PIX_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    tlr_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    tlr_out_t         m_data;

    fit_scoreboard sb = new;
    int send_idle_pct = 25;
    int recv_idle_pct = 54;
    int stall_cycles  = 0;

    thresholded_linear_regression_fit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every fit word taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_fit(m_data);
        end
    end

    // Give up when no channel has moved a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one pixel word, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic last);
        tlr_in_t w;
        w.ref_pixel    = x;
        w.scaled_pixel = y;
        w.last_pixel   = last;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(w);
    endtask

    // Holds the sender off until every fit word due has arrived.
    task automatic drain_fits();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Writes the threshold once the block has gone idle.
    task automatic write_threshold(input logic [PIX_W-1:0] value);
        drain_fits();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.threshold = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Reference pixel biased toward the extremes and the threshold edge.
    function automatic logic [PIX_W-1:0] pick_ref(input int thr);
        int r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return '1;
            2: return PIX_W'(thr);
            3: return (thr > 0) ? PIX_W'(thr - 1) : '0;
            default: return PIX_W'($urandom_range(4095));
        endcase
    endfunction

    // Sends one image; its shape picks constant, below-threshold or mixed data.
    task automatic send_image(input int len, input int thr, inout int words_sent);
        int               shape;
        int               const_x;
        int               gain;
        int               offset;
        int               v;
        int               i;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        shape   = $urandom_range(9);
        const_x = $urandom_range(4095);
        gain    = $urandom_range(64);
        offset  = int'($urandom_range(4095)) - 2048;
        for (i = 0; i < len; i++) begin
            if (shape == 0) begin
                x = PIX_W'(const_x);
            end else if (shape == 1 && thr > 0) begin
                x = PIX_W'($urandom_range(thr - 1));
            end else begin
                x = pick_ref(thr);
            end
            if (shape >= 6) begin
                // Roughly linear data so the fit lands in a useful range.
                v = (gain * int'(x)) / 32 + offset + int'($urandom_range(64)) - 32;
                y = (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : PIX_W'(v);
            end else begin
                y = ($urandom_range(9) == 0) ? {PIX_W{$urandom_range(1) == 1}}
                                             : PIX_W'($urandom_range(4095));
            end
            send_pixel(x, y, i == len - 1);
            words_sent++;
        end
    endtask

    initial begin
        int words_sent;
        int seg;
        int seg_start;
        int len;
        int r;
        int thr;
        sb.reset_state();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed images at the reset threshold of zero.
        send_pixel(12'd0, 12'd0, 1'b1);          // single pair, degenerate
        send_pixel(12'd0, 12'd4095, 1'b0);       // full-scale falling line
        send_pixel(12'd4095, 12'd0, 1'b1);
        send_pixel(12'd4095, 12'd4095, 1'b0);    // full-scale rising line
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd100, 12'd100, 1'b0);      // negative intercept
        send_pixel(12'd200, 12'd300, 1'b1);
        send_pixel(12'd77, 12'd5, 1'b0);         // all x equal, degenerate
        send_pixel(12'd77, 12'd4095, 1'b0);
        send_pixel(12'd77, 12'd0, 1'b1);

        // Top threshold: nothing used, then only the top value used.
        write_threshold(12'd4095);
        send_pixel(12'd4094, 12'd4095, 1'b0);
        send_pixel(12'd0, 12'd1, 1'b1);
        send_pixel(12'd4095, 12'd12, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b1);
        send_pixel(12'd4095, 12'd3, 1'b0);       // last pair itself excluded
        send_pixel(12'd1, 12'd9, 1'b1);

        // Mid threshold with pairs on both sides of it.
        write_threshold(12'd2048);
        send_pixel(12'd2047, 12'd100, 1'b0);
        send_pixel(12'd2048, 12'd3000, 1'b0);
        send_pixel(12'd4000, 12'd20, 1'b0);
        send_pixel(12'd2049, 12'd4095, 1'b1);

        // Random images in six segments, two per idle pattern.
        words_sent = 0;
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: thr = 0;
                1: thr = $urandom_range(1, 2047);
                2: thr = $urandom_range(2048, 4094);
                3: thr = 4095;
                4: thr = $urandom_range(4095);
                default: thr = 0;
            endcase
            write_threshold(PIX_W'(thr));
            if (seg == 2) begin
                send_idle_pct = 54;
                recv_idle_pct = 25;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            seg_start = words_sent;
            while (words_sent - seg_start < SEG_WORDS) begin
                r = $urandom_range(9);
                if (r == 9) begin
                    len = 1;
                end else if (r >= 7) begin
                    len = $urandom_range(17, 64);
                end else begin
                    len = $urandom_range(2, 16);
                end
                send_image(len, thr, words_sent);
            end
        end

        // Let every fit word arrive, then watch for strays.
        drain_fits();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_ctrl.sv
hw/rtl/tlr_dp.sv
hw/rtl/thresholded_linear_regression_fit.sv
tb/tb_top.sv
